@@ src/macd_pkg.sv @@
// Shared constants, types and helper functions of the MACD indicator.
package macd_pkg;

  localparam int MAX_PERIOD = 64;
  localparam int FRAC_BITS  = 16;
  localparam int EXTRA_BITS = 8;
  localparam int ACC_W      = 48;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_FAST_PERIOD   = 3'd0;
  localparam cfg_idx_t CFG_SLOW_PERIOD   = 3'd1;
  localparam cfg_idx_t CFG_SIGNAL_PERIOD = 3'd2;
  localparam cfg_idx_t CFG_FAST_ALPHA    = 3'd3;
  localparam cfg_idx_t CFG_SLOW_ALPHA    = 3'd4;
  localparam cfg_idx_t CFG_SIGNAL_ALPHA  = 3'd5;

  typedef enum logic [1:0] {
    AVG_FAST,
    AVG_SLOW,
    AVG_SIG
  } avg_sel_t;

  function automatic logic [6:0] clamp_period(input logic [6:0] p);
    logic [6:0] r;
    if (p < 7'd2) begin
      r = 7'd2;
    end else if (p > 7'(MAX_PERIOD)) begin
      r = 7'(MAX_PERIOD);
    end else begin
      r = p;
    end
    return r;
  endfunction

  function automatic logic [55:0] mul100(input logic [48:0] x);
    logic [55:0] w;
    w = {7'b0, x};
    return (w << 6) + (w << 5) + (w << 2);
  endfunction

  function automatic logic [31:0] pct_final(input logic neg, input logic sat,
                                            input logic [31:0] q);
    logic [31:0] lim;
    logic [31:0] v;
    lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    v = (sat || q > lim) ? lim : q;
    return neg ? (32'd0 - v) : v;
  endfunction

endpackage

@@ src/macd_indicator.sv @@
// MACD indicator: price change, percent change, MACD and signal percent per price.
//
// Input channel (in_valid/in_ready) takes one Q16.16 closing price per transfer;
// in_series_start clears all running averages and counts before that price.
// Output channel (out_valid/out_ready) returns exactly one result per input item.
// Configuration: cfg_we writes cfg_wdata into register cfg_index at the clock edge;
// write only while the block is idle. Unknown indexes are dropped.
// One item is worked at a time; in_ready is high only in the idle state.
// Latency is set by the shared restoring divider (one quotient bit per cycle),
// which works each percent and each seed mean; each EMA update passes the
// states ST_AVG, ST_MUL_HI and ST_EMA_FIN. The longest item holds one seed
// mean division plus three percent divisions.
// A finished result waits in the output register; while the receiver stalls,
// the next item may be accepted and is worked up to its final load.
// Synchronous active-low reset restores the default periods and alphas and
// clears all series state; no result is pending after reset.
module macd_indicator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [31:0]           in_price,
  input  logic                  in_series_start,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [32:0]    out_price_change,
  output logic signed [31:0]    out_pct_change,
  output logic signed [31:0]    out_macd_percent,
  output logic signed [31:0]    out_signal_percent,
  output logic                  out_change_valid,
  output logic                  out_macd_valid,
  input  logic                  cfg_we,
  input  macd_pkg::cfg_idx_t    cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import macd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CHANGE, ST_PCHG_WR, ST_AVG, ST_MUL_HI, ST_EMA_FIN, ST_MEAN_WR,
    ST_MACD, ST_MP, ST_MP_WR, ST_GP_WR, ST_DIV, ST_DONE
  } state_t;

  state_t state_r, ret_r;
  avg_sel_t sel_r;

  logic [6:0]  fast_period_r, slow_period_r, signal_period_r;
  logic [15:0] fast_alpha_r, slow_alpha_r, signal_alpha_r;

  logic [7:0]  cnt_r, mcnt_r;
  logic [31:0] prev_r, price_r;
  logic signed [ACC_W-1:0] fast_acc_r, slow_acc_r, sig_acc_r;
  logic signed [48:0] m_r;
  logic signed [32:0] chg_r;
  logic cv_r, mv_r;
  logic [31:0] pchg_r, mp_r, gp_r;

  logic [49:0] mag_r;
  logic        dneg_r;
  logic [47:0] mul_r;
  logic [63:0] prod_r;

  logic [32:0] div_rem_r;
  logic [47:0] div_dvd_r, div_q_r;
  logic [31:0] div_den_r;
  logic [5:0]  div_cnt_r;
  logic        div_neg_r, div_sat_r;

  logic [6:0] fp, sp, gp;
  logic signed [ACC_W-1:0] acc_cur;
  logic [7:0]  idx_cur;
  logic [6:0]  per_cur;
  logic signed [49:0] x_cur;
  logic [15:0] alpha_cur;

  logic signed [ACC_W-1:0] seed_sum;
  logic [47:0] seed_mag;
  logic        seeding, last_seed;
  logic signed [49:0] ema_d;
  logic [49:0] ema_mag;
  logic [33:0] mul_hi;
  logic [63:0] prod_nxt, ema_round;
  logic [47:0] ema_p;
  logic signed [ACC_W-1:0] ema_nxt, mean_nxt;

  logic signed [32:0] chg_nxt;
  logic [32:0] chg_mag;
  logic signed [ACC_W-1:0] fe;
  logic signed [48:0] m_nxt;
  logic [48:0] m_mag;
  logic [47:0] sig_mag;
  logic [7:0]  cnt_inc, mcnt_inc;
  logic [7:0]  sg_sum;
  logic        mv_nxt;

  logic [55:0] pct_num;
  logic [31:0] pct_den;
  logic        pct_s16, pct_neg;
  logic [71:0] pct_d;
  logic        pct_sat;
  logic [31:0] pct_res;

  logic [32:0] rem2, rem_nxt;
  logic        qbit;

  assign fp = clamp_period(fast_period_r);
  assign sp = clamp_period(slow_period_r);
  assign gp = clamp_period(signal_period_r);

  always_comb begin
    unique case (sel_r)
      AVG_SLOW: begin
        acc_cur = slow_acc_r; idx_cur = cnt_r; per_cur = sp;
        x_cur = {10'b0, price_r, 8'b0}; alpha_cur = slow_alpha_r;
      end
      AVG_SIG: begin
        acc_cur = sig_acc_r; idx_cur = mcnt_r; per_cur = gp;
        x_cur = {m_r[48], m_r}; alpha_cur = signal_alpha_r;
      end
      default: begin
        acc_cur = fast_acc_r; idx_cur = cnt_r; per_cur = fp;
        x_cur = {10'b0, price_r, 8'b0}; alpha_cur = fast_alpha_r;
      end
    endcase
  end

  assign seeding   = idx_cur < {1'b0, per_cur};
  assign last_seed = idx_cur == ({1'b0, per_cur} - 8'd1);
  assign seed_sum  = acc_cur + x_cur[47:0];
  assign seed_mag  = seed_sum[47] ? (48'd0 - seed_sum) : seed_sum;
  assign ema_d     = x_cur - {{2{acc_cur[47]}}, acc_cur};
  assign ema_mag   = ema_d[49] ? (50'd0 - ema_d) : ema_d;
  assign mul_hi    = mag_r[49:32] * alpha_cur;
  assign prod_nxt  = {16'b0, mul_r} + {mul_hi[31:0], 32'b0};
  assign ema_round = prod_r + 64'd32768;
  assign ema_p     = ema_round[63:16];
  assign ema_nxt   = dneg_r ? (acc_cur - ema_p) : (acc_cur + ema_p);
  assign mean_nxt  = div_neg_r ? (48'd0 - div_q_r) : div_q_r;

  assign chg_nxt = {1'b0, price_r} - {1'b0, prev_r};
  assign chg_mag = chg_nxt[32] ? (33'd0 - chg_nxt) : chg_nxt;
  assign fe      = (cnt_r >= ({1'b0, fp} - 8'd1)) ? fast_acc_r : '0;
  assign m_nxt   = {fe[47], fe} - {slow_acc_r[47], slow_acc_r};
  assign m_mag   = m_r[48] ? (49'd0 - m_r) : m_r;
  assign sig_mag = sig_acc_r[47] ? (48'd0 - sig_acc_r) : sig_acc_r;
  assign cnt_inc  = (cnt_r == 8'hFF) ? cnt_r : cnt_r + 8'd1;
  assign mcnt_inc = (mcnt_r == 8'hFF) ? mcnt_r : mcnt_r + 8'd1;
  assign sg_sum   = {1'b0, sp} + {1'b0, gp};
  assign mv_nxt   = (cnt_inc >= sg_sum) && (mcnt_inc >= {1'b0, gp}) && (price_r != 32'd0);

  always_comb begin
    unique case (state_r)
      ST_CHANGE: begin
        pct_num = mul100({16'b0, chg_mag}); pct_den = prev_r;
        pct_s16 = 1'b1; pct_neg = chg_nxt[32];
      end
      ST_MP_WR: begin
        pct_num = mul100({1'b0, sig_mag}); pct_den = price_r;
        pct_s16 = 1'b0; pct_neg = sig_acc_r[47];
      end
      default: begin
        pct_num = mul100(m_mag); pct_den = price_r;
        pct_s16 = 1'b0; pct_neg = m_r[48];
      end
    endcase
  end

  assign pct_d   = pct_s16 ? {pct_num, 16'b0} : {8'b0, pct_num, 8'b0};
  assign pct_sat = pct_d[71:32] >= {8'b0, pct_den};
  assign pct_res = pct_final(div_neg_r, div_sat_r, div_q_r[31:0]);

  assign rem2    = {div_rem_r[31:0], div_dvd_r[47]};
  assign qbit    = rem2 >= {1'b0, div_den_r};
  assign rem_nxt = qbit ? (rem2 - {1'b0, div_den_r}) : rem2;

  assign in_ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r <= ST_IDLE;
      sel_r <= AVG_FAST;
      fast_period_r <= 7'd12;
      slow_period_r <= 7'd26;
      signal_period_r <= 7'd9;
      fast_alpha_r <= 16'd10082;
      slow_alpha_r <= 16'd4855;
      signal_alpha_r <= 16'd13107;
      cnt_r <= '0;
      mcnt_r <= '0;
      prev_r <= '0;
      fast_acc_r <= '0;
      slow_acc_r <= '0;
      sig_acc_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FAST_PERIOD:   fast_period_r <= cfg_wdata[6:0];
          CFG_SLOW_PERIOD:   slow_period_r <= cfg_wdata[6:0];
          CFG_SIGNAL_PERIOD: signal_period_r <= cfg_wdata[6:0];
          CFG_FAST_ALPHA:    fast_alpha_r <= cfg_wdata;
          CFG_SLOW_ALPHA:    slow_alpha_r <= cfg_wdata;
          CFG_SIGNAL_ALPHA:  signal_alpha_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid && out_ready && state_r != ST_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            price_r <= in_price;
            if (in_series_start) begin
              cnt_r <= '0;
              mcnt_r <= '0;
              prev_r <= '0;
              fast_acc_r <= '0;
              slow_acc_r <= '0;
              sig_acc_r <= '0;
            end
            state_r <= ST_CHANGE;
          end
        end
        ST_CHANGE: begin
          cv_r <= cnt_r != 8'd0;
          chg_r <= (cnt_r != 8'd0) ? chg_nxt : '0;
          pchg_r <= '0;
          sel_r <= AVG_FAST;
          if (cnt_r != 8'd0 && prev_r != 32'd0) begin
            div_rem_r <= pct_d[64:32];
            div_dvd_r <= {pct_d[31:0], 16'b0};
            div_den_r <= pct_den;
            div_q_r <= '0;
            div_cnt_r <= 6'd32;
            div_neg_r <= pct_neg;
            div_sat_r <= pct_sat;
            ret_r <= ST_PCHG_WR;
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_AVG;
          end
        end
        ST_PCHG_WR: begin
          pchg_r <= pct_res;
          state_r <= ST_AVG;
        end
        ST_AVG: begin
          if (seeding) begin
            unique case (sel_r)
              AVG_SLOW: slow_acc_r <= seed_sum;
              AVG_SIG:  sig_acc_r <= seed_sum;
              default:  fast_acc_r <= seed_sum;
            endcase
            if (last_seed) begin
              div_rem_r <= '0;
              div_dvd_r <= seed_mag;
              div_den_r <= {25'b0, per_cur};
              div_q_r <= '0;
              div_cnt_r <= 6'd48;
              div_neg_r <= seed_sum[47];
              div_sat_r <= 1'b0;
              ret_r <= ST_MEAN_WR;
              state_r <= ST_DIV;
            end else begin
              priority case (sel_r)
                AVG_FAST: begin sel_r <= AVG_SLOW; state_r <= ST_AVG; end
                AVG_SLOW: state_r <= ST_MACD;
                default:  state_r <= ST_MP;
              endcase
            end
          end else begin
            mag_r <= ema_mag;
            dneg_r <= ema_d[49];
            mul_r <= ema_mag[31:0] * alpha_cur;
            state_r <= ST_MUL_HI;
          end
        end
        ST_MUL_HI: begin
          prod_r <= prod_nxt;
          state_r <= ST_EMA_FIN;
        end
        ST_EMA_FIN, ST_MEAN_WR: begin
          unique case (sel_r)
            AVG_SLOW: slow_acc_r <= (state_r == ST_MEAN_WR) ? mean_nxt : ema_nxt;
            AVG_SIG:  sig_acc_r <= (state_r == ST_MEAN_WR) ? mean_nxt : ema_nxt;
            default:  fast_acc_r <= (state_r == ST_MEAN_WR) ? mean_nxt : ema_nxt;
          endcase
          priority case (sel_r)
            AVG_FAST: begin sel_r <= AVG_SLOW; state_r <= ST_AVG; end
            AVG_SLOW: state_r <= ST_MACD;
            default:  state_r <= ST_MP;
          endcase
        end
        ST_MACD: begin
          mp_r <= '0;
          gp_r <= '0;
          mv_r <= 1'b0;
          if (cnt_r >= ({1'b0, sp} - 8'd1)) begin
            m_r <= m_nxt;
            sel_r <= AVG_SIG;
            state_r <= ST_AVG;
          end else begin
            cnt_r <= cnt_inc;
            state_r <= ST_DONE;
          end
        end
        ST_MP: begin
          cnt_r <= cnt_inc;
          mcnt_r <= mcnt_inc;
          mv_r <= mv_nxt;
          if (mv_nxt) begin
            div_rem_r <= pct_d[64:32];
            div_dvd_r <= {pct_d[31:0], 16'b0};
            div_den_r <= pct_den;
            div_q_r <= '0;
            div_cnt_r <= 6'd32;
            div_neg_r <= pct_neg;
            div_sat_r <= pct_sat;
            ret_r <= ST_MP_WR;
            state_r <= ST_DIV;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_MP_WR: begin
          mp_r <= pct_res;
          div_rem_r <= pct_d[64:32];
          div_dvd_r <= {pct_d[31:0], 16'b0};
          div_den_r <= pct_den;
          div_q_r <= '0;
          div_cnt_r <= 6'd32;
          div_neg_r <= pct_neg;
          div_sat_r <= pct_sat;
          ret_r <= ST_GP_WR;
          state_r <= ST_DIV;
        end
        ST_GP_WR: begin
          gp_r <= pct_res;
          state_r <= ST_DONE;
        end
        ST_DIV: begin
          div_rem_r <= rem_nxt;
          div_dvd_r <= {div_dvd_r[46:0], 1'b0};
          div_q_r <= {div_q_r[46:0], qbit};
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == 6'd1) begin
            state_r <= ret_r;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_price_change <= chg_r;
            out_pct_change <= pchg_r;
            out_macd_percent <= mp_r;
            out_signal_percent <= gp_r;
            out_change_valid <= cv_r;
            out_macd_valid <= mv_r;
            prev_r <= price_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  a_macd_needs_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_macd_valid |-> out_change_valid)
    else $error("macd valid without change valid");

  a_macd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_macd_valid |-> out_macd_percent == 32'sd0 && out_signal_percent == 32'sd0)
    else $error("macd percent nonzero while not valid");

  a_change_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_change_valid |-> out_price_change == 33'sd0 && out_pct_change == 32'sd0)
    else $error("change nonzero on first sample");

endmodule
